// ===== design/mfep_pkg.sv =====
// package: phases, result kinds and constants for the midi file event parser
package mfep_pkg;

   localparam int VarintMaxBytesDefault = 4;

   typedef enum logic [4:0] {
      PH_MAGIC  = 5'd0,
      PH_HLEN   = 5'd1,
      PH_FMT    = 5'd2,
      PH_NTRK   = 5'd3,
      PH_TPQN   = 5'd4,
      PH_CID    = 5'd5,
      PH_CLEN   = 5'd6,
      PH_CSKIP  = 5'd7,
      PH_DELTA  = 5'd8,
      PH_STATUS = 5'd9,
      PH_DATA1  = 5'd10,
      PH_DATA2  = 5'd11,
      PH_MTYPE  = 5'd12,
      PH_MLEN   = 5'd13,
      PH_TEMPO  = 5'd14,
      PH_TSIG   = 5'd15,
      PH_SXLEN  = 5'd16,
      PH_ESKIP  = 5'd17,
      PH_TAIL   = 5'd18,
      PH_DONE   = 5'd19,
      PH_ERROR  = 5'd20
   } phase_type;

   typedef enum logic [2:0] {
      KIND_HEADER  = 3'd0,
      KIND_CHANNEL = 3'd1,
      KIND_TEMPO   = 3'd2,
      KIND_TSIG    = 3'd3,
      KIND_EOT     = 3'd4,
      KIND_ERROR   = 3'd5
   } kind_type;

   localparam logic [31:0] TagMthd = 32'h4D546864;
   localparam logic [31:0] TagMtrk = 32'h4D54726B;
   localparam logic [7:0]  MetaByte = 8'hFF;
   localparam logic [7:0]  SysexStart = 8'hF0;
   localparam logic [7:0]  SysexCont = 8'hF7;
   localparam logic [7:0]  MetaTempo = 8'h51;
   localparam logic [7:0]  MetaTsig = 8'h58;
   localparam logic [7:0]  MetaEot = 8'h2F;
   localparam logic [3:0]  NibProg = 4'hC;
   localparam logic [3:0]  NibPress = 4'hD;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] track_index;
      logic [31:0] tick;
      logic [7:0]  status_byte;
      logic [7:0]  first_data;
      logic [7:0]  second_data;
      logic [23:0] wide_value;
      logic [15:0] track_total;
      logic        last;
   } rsp_item_type;

endpackage

// ===== design/mfep_if.sv =====
// interfaces: file byte request channel and result channel
interface mfep_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] file_byte;
   logic       new_file;
   modport source (output valid, output file_byte, output new_file, input ready);
   modport sink (input valid, input file_byte, input new_file, output ready);
endinterface

interface mfep_rsp_if
   import mfep_pkg::*;
;
   logic         valid;
   logic         ready;
   rsp_item_type item;
   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

// ===== design/mfep_core.sv =====
// parser state update: one file byte in, up to two result items out
module mfep_core
   import mfep_pkg::*;
#(
   parameter int VARINT_MAX_BYTES = VarintMaxBytesDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  logic [7:0]   file_byte,
   input  logic         new_file,
   output logic [1:0]   res_count,
   output rsp_item_type res0,
   output rsp_item_type res1
);

   phase_type   phase_ff, phase_in;
   logic [2:0]  pos_ff, pos_in;
   logic [31:0] chunk_ff, chunk_in;
   logic [31:0] skip_ff, skip_in;
   logic [31:0] vacc_ff, vacc_in;
   logic [2:0]  vcnt_ff, vcnt_in;
   logic [31:0] tick_ff, tick_in;
   logic [7:0]  run_ff, run_in;
   logic [7:0]  hstat_ff, hstat_in;
   logic [7:0]  hdata_ff, hdata_in;
   logic [7:0]  mtype_ff, mtype_in;
   logic [31:0] mlen_ff, mlen_in;
   logic [31:0] facc_ff, facc_in;
   logic [15:0] texp_ff, texp_in;
   logic [15:0] tdone_ff, tdone_in;

   always_comb begin
      phase_type   ph;
      logic [2:0]  pos;
      logic [31:0] chunk, skip, vacc, facc, tick, mlen, vnew, cnext;
      logic [2:0]  vcnt, vcnew, posn;
      logic [7:0]  run, hstat, hdata, mtype, b, magic;
      logic [15:0] texp, tdone;
      logic [1:0]  n;
      logic        vdone;
      rsp_item_type r0, r1, e;
      ph = phase_ff; pos = pos_ff; chunk = chunk_ff; skip = skip_ff;
      vacc = vacc_ff; vcnt = vcnt_ff; tick = tick_ff; run = run_ff;
      hstat = hstat_ff; hdata = hdata_ff; mtype = mtype_ff; mlen = mlen_ff;
      facc = facc_ff; texp = texp_ff; tdone = tdone_ff;
      b = file_byte;
      n = 2'd0;
      r0 = '0; r1 = '0; e = '0;
      vnew = {vacc_ff[24:0], b[6:0]};
      vcnew = vcnt_ff + 3'd1;
      vdone = !b[7] || ({29'd0, vcnew} >= 32'(VARINT_MAX_BYTES));
      posn = pos_ff + 3'd1;
      cnext = 32'd0;
      if (new_file) begin
         ph = PH_MAGIC; pos = '0; chunk = '0; skip = '0; vacc = '0; vcnt = '0;
         tick = '0; run = '0; hstat = '0; hdata = '0; mtype = '0; mlen = '0;
         facc = '0; texp = '0; tdone = '0;
         posn = 3'd1;
      end
      case (pos[1:0])
         2'd0: magic = TagMthd[31:24];
         2'd1: magic = TagMthd[23:16];
         2'd2: magic = TagMthd[15:8];
         default: magic = TagMthd[7:0];
      endcase
      case (ph)
         PH_MAGIC: begin
            if (b != magic) begin
               e = '0; e.kind = KIND_ERROR; r0 = e; n = 2'd1; ph = PH_ERROR;
            end else if (posn >= 3'd4) begin
               pos = '0; chunk = '0; ph = PH_HLEN;
            end else pos = posn;
         end
         PH_HLEN: begin
            chunk = {chunk[23:0], b};
            if (posn >= 3'd4) begin
               pos = '0;
               if (chunk < 32'd6) begin
                  e = '0; e.kind = KIND_ERROR; r0 = e; n = 2'd1; ph = PH_ERROR;
               end else ph = PH_FMT;
            end else pos = posn;
         end
         PH_FMT: begin
            if (posn >= 3'd2) begin
               pos = '0; texp = '0; ph = PH_NTRK;
            end else pos = posn;
         end
         PH_NTRK: begin
            texp = {texp[7:0], b};
            if (posn >= 3'd2) begin
               pos = '0; facc = '0; ph = PH_TPQN;
            end else pos = posn;
         end
         PH_TPQN: begin
            facc = {16'd0, facc[7:0], b};
            if (posn >= 3'd2) begin
               pos = '0;
               e = '0; e.kind = KIND_HEADER; e.wide_value = facc[23:0];
               e.track_total = texp;
               r0 = e; n = 2'd1;
               skip = chunk - 32'd6;
               if (texp == 16'd0) ph = PH_DONE;
               else if (skip != 32'd0) ph = PH_CSKIP;
               else begin
                  ph = PH_CID; pos = '0; facc = '0;
               end
            end else pos = posn;
         end
         PH_CID: begin
            facc = {facc[23:0], b};
            if (posn >= 3'd4) begin
               pos = '0; chunk = '0; ph = PH_CLEN;
            end else pos = posn;
         end
         PH_CLEN: begin
            chunk = {chunk[23:0], b};
            if (posn >= 3'd4) begin
               pos = '0;
               if (facc == TagMtrk) begin
                  tick = '0; run = '0;
                  if (chunk == 32'd0) begin
                     e = '0; e.kind = KIND_EOT; e.track_index = tdone;
                     r0 = e; n = 2'd1;
                     tdone = tdone + 16'd1;
                     if (tdone == texp) ph = PH_DONE;
                     else begin
                        ph = PH_CID; facc = '0;
                     end
                  end else begin
                     ph = PH_DELTA; vacc = '0; vcnt = '0;
                  end
               end else if (chunk == 32'd0) begin
                  ph = PH_CID; facc = '0;
               end else begin
                  skip = chunk; ph = PH_CSKIP;
               end
            end else pos = posn;
         end
         PH_CSKIP: begin
            if (skip != 32'd0) skip = skip - 32'd1;
            if (skip == 32'd0) begin
               ph = PH_CID; pos = '0; facc = '0;
            end
         end
         PH_DONE, PH_ERROR: begin
         end
         default: begin
            if (chunk != 32'd0) chunk = chunk - 32'd1;
            cnext = chunk;
            case (ph)
               PH_DELTA: begin
                  vacc = vnew; vcnt = vcnew;
                  if (vdone) begin
                     tick = tick + vnew; ph = PH_STATUS;
                  end
               end
               PH_STATUS: begin
                  if (!b[7]) begin
                     if (run == 8'd0) begin
                        e = '0; e.kind = KIND_EOT; e.track_index = tdone;
                        e.tick = tick; r0 = e; n = 2'd1;
                        tdone = tdone + 16'd1; ph = PH_TAIL;
                     end else begin
                        hstat = run; hdata = b;
                        if (run[7:4] == NibProg || run[7:4] == NibPress) begin
                           e = '0; e.kind = KIND_CHANNEL; e.track_index = tdone;
                           e.tick = tick; e.status_byte = run; e.first_data = b;
                           r0 = e; n = 2'd1;
                           ph = PH_DELTA; vacc = '0; vcnt = '0;
                        end else ph = PH_DATA2;
                     end
                  end else if (b == MetaByte) ph = PH_MTYPE;
                  else if (b == SysexStart || b == SysexCont) begin
                     run = '0; vacc = '0; vcnt = '0; ph = PH_SXLEN;
                  end else begin
                     run = b; hstat = b; ph = PH_DATA1;
                  end
               end
               PH_DATA1: begin
                  hdata = b;
                  if (hstat[7:4] == NibProg || hstat[7:4] == NibPress) begin
                     e = '0; e.kind = KIND_CHANNEL; e.track_index = tdone;
                     e.tick = tick; e.status_byte = hstat; e.first_data = b;
                     r0 = e; n = 2'd1;
                     ph = PH_DELTA; vacc = '0; vcnt = '0;
                  end else ph = PH_DATA2;
               end
               PH_DATA2: begin
                  e = '0; e.kind = KIND_CHANNEL; e.track_index = tdone;
                  e.tick = tick; e.status_byte = hstat; e.first_data = hdata;
                  e.second_data = b;
                  r0 = e; n = 2'd1;
                  ph = PH_DELTA; vacc = '0; vcnt = '0;
               end
               PH_MTYPE: begin
                  mtype = b;
                  if (b == MetaEot) begin
                     e = '0; e.kind = KIND_EOT; e.track_index = tdone;
                     e.tick = tick; r0 = e; n = 2'd1;
                     tdone = tdone + 16'd1; ph = PH_TAIL;
                  end else begin
                     vacc = '0; vcnt = '0; ph = PH_MLEN;
                  end
               end
               PH_MLEN: begin
                  vacc = vnew; vcnt = vcnew;
                  if (vdone) begin
                     mlen = vnew; pos = '0; facc = '0;
                     if (mtype == MetaTempo && vnew == 32'd3) ph = PH_TEMPO;
                     else if (mtype == MetaTsig && vnew >= 32'd4) ph = PH_TSIG;
                     else if (vnew == 32'd0) begin
                        ph = PH_DELTA; vacc = '0; vcnt = '0;
                     end else begin
                        skip = vnew; ph = PH_ESKIP;
                     end
                  end
               end
               PH_TEMPO: begin
                  facc = {8'd0, facc[15:0], b};
                  if (posn >= 3'd3) begin
                     pos = '0;
                     if (facc != 32'd0) begin
                        e = '0; e.kind = KIND_TEMPO; e.track_index = tdone;
                        e.tick = tick; e.wide_value = facc[23:0];
                        r0 = e; n = 2'd1;
                     end
                     ph = PH_DELTA; vacc = '0; vcnt = '0;
                  end else pos = posn;
               end
               PH_TSIG: begin
                  if (pos == 3'd0) hdata = b;
                  else if (pos == 3'd1)
                     facc = (b < 8'd8) ? {24'd0, 8'd1 << b[2:0]} : 32'd0;
                  if (posn >= 3'd4) begin
                     pos = '0;
                     e = '0; e.kind = KIND_TSIG; e.track_index = tdone;
                     e.tick = tick; e.first_data = hdata; e.second_data = facc[7:0];
                     r0 = e; n = 2'd1;
                     if (mlen == 32'd4) begin
                        ph = PH_DELTA; vacc = '0; vcnt = '0;
                     end else begin
                        skip = mlen - 32'd4; ph = PH_ESKIP;
                     end
                  end else pos = posn;
               end
               PH_SXLEN: begin
                  vacc = vnew; vcnt = vcnew;
                  if (vdone) begin
                     if (vnew == 32'd0) begin
                        ph = PH_DELTA; vacc = '0; vcnt = '0;
                     end else begin
                        skip = vnew; ph = PH_ESKIP;
                     end
                  end
               end
               PH_ESKIP: begin
                  if (skip != 32'd0) skip = skip - 32'd1;
                  if (skip == 32'd0) begin
                     ph = PH_DELTA; vacc = '0; vcnt = '0;
                  end
               end
               default: begin
               end
            endcase
            if (cnext == 32'd0) begin
               if (ph != PH_TAIL) begin
                  e = '0; e.kind = KIND_EOT; e.track_index = tdone;
                  e.tick = tick;
                  if (n == 2'd0) r0 = e;
                  else r1 = e;
                  n = n + 2'd1;
                  tdone = tdone + 16'd1;
               end
               if (tdone == texp) ph = PH_DONE;
               else begin
                  ph = PH_CID; pos = '0; facc = '0;
               end
            end
         end
      endcase
      if (n == 2'd1) r0.last = 1'b1;
      if (n == 2'd2) r1.last = 1'b1;
      res_count = n; res0 = r0; res1 = r1;
      phase_in = ph; pos_in = pos; chunk_in = chunk; skip_in = skip;
      vacc_in = vacc; vcnt_in = vcnt; tick_in = tick; run_in = run;
      hstat_in = hstat; hdata_in = hdata; mtype_in = mtype; mlen_in = mlen;
      facc_in = facc; texp_in = texp; tdone_in = tdone;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MAGIC; pos_ff <= '0; chunk_ff <= '0; skip_ff <= '0;
         vacc_ff <= '0; vcnt_ff <= '0; tick_ff <= '0; run_ff <= '0;
         hstat_ff <= '0; hdata_ff <= '0; mtype_ff <= '0; mlen_ff <= '0;
         facc_ff <= '0; texp_ff <= '0; tdone_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in; pos_ff <= pos_in; chunk_ff <= chunk_in;
         skip_ff <= skip_in; vacc_ff <= vacc_in; vcnt_ff <= vcnt_in;
         tick_ff <= tick_in; run_ff <= run_in; hstat_ff <= hstat_in;
         hdata_ff <= hdata_in; mtype_ff <= mtype_in; mlen_ff <= mlen_in;
         facc_ff <= facc_in; texp_ff <= texp_in; tdone_ff <= tdone_in;
      end
   end

endmodule

// ===== design/midi_file_event_parser_top.sv =====
// top level: midi file event parser with input register and four-entry result queue
//
//  channel | dir | handshake          | payload
//  req     | in  | req.valid/ready    | file_byte, new_file
//  rsp     | out | rsp.valid/ready    | kind, track_index, tick, ... , last
//
// a byte is registered on accept and parsed in the next cycle, one byte per cycle while req.ready stays high
// its items go from the input register through the parser into the result queue, and rsp is driven from the queue
// each byte gives zero, one or two items into a four-entry result queue
// req.ready drops when fewer than two entries would be free after the pending push
// reset is synchronous and clears the parser state and the queue
module midi_file_event_parser_top
   import mfep_pkg::*;
#(
   parameter int VARINT_MAX_BYTES = VarintMaxBytesDefault
) (
   input logic clock,
   input logic reset,
   mfep_req_if.sink   req,
   mfep_rsp_if.source rsp
);

   logic         in_valid_ff;
   logic [7:0]   in_byte_ff;
   logic         in_new_ff;
   logic [1:0]   res_count;
   rsp_item_type res0, res1;
   rsp_item_type q_ff [4];
   logic [1:0]   rd_ff, wr_ff;
   logic [2:0]   cnt_ff, cnt_in;
   logic [1:0]   push;
   logic         pop;

   mfep_core #(.VARINT_MAX_BYTES(VARINT_MAX_BYTES)) u_core (
      .clock(clock), .reset(reset), .step(in_valid_ff),
      .file_byte(in_byte_ff), .new_file(in_new_ff),
      .res_count(res_count), .res0(res0), .res1(res1)
   );

   // room for two items once the byte in the register has been counted
   assign req.ready = (cnt_ff + {1'b0, push}) <= 3'd2;
   assign push = in_valid_ff ? res_count : 2'd0;
   assign pop = rsp.valid && rsp.ready;
   assign cnt_in = cnt_ff + {1'b0, push} - {2'b0, pop};
   assign rsp.valid = cnt_ff != 3'd0;
   assign rsp.item = q_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rd_ff <= '0; wr_ff <= '0; cnt_ff <= '0;
      end else begin
         in_valid_ff <= req.valid && req.ready;
         if (pop) rd_ff <= rd_ff + 2'd1;
         wr_ff <= wr_ff + push;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff <= req.file_byte;
         in_new_ff <= req.new_file;
      end
      if (push != 2'd0) q_ff[wr_ff] <= res0;
      if (push == 2'd2) q_ff[wr_ff + 2'd1] <= res1;
   end

endmodule

// ===== design/mfep_checker.sv =====
// checker: port level properties of the midi file event parser
module mfep_checker
   import mfep_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_item_type rsp_item
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("rsp item changed while stalled");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.kind <= KIND_ERROR)
      else $error("rsp kind out of range");

   a_no_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !(req_valid && req_ready) && !$past(req_valid && req_ready)
      |=> !rsp_valid)
      else $error("rsp item without a byte");

   a_err_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.kind == KIND_ERROR |-> rsp_item.tick == 32'd0 && rsp_item.last)
      else $error("error item malformed");

endmodule

bind midi_file_event_parser_top mfep_checker u_mfep_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_item(rsp.item)
);

// ===== tb/mfep_scoreboard.sv =====
// checker: watches both channels, predicts parser results and compares them
module mfep_scoreboard
   import mfep_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   mfep_req_if.sink   req_mon,
   mfep_rsp_if.sink   rsp_mon,
   output int         error_count,
   output int         pending_count,
   output int         result_count
);

   phase_type    ph;
   logic [2:0]   bpos;
   logic [31:0]  chunk_left;
   logic [31:0]  skip_left;
   logic [31:0]  vacc;
   logic [2:0]   vcnt;
   logic [31:0]  ticks;
   logic [7:0]   run_st;
   logic [7:0]   hold_st;
   logic [7:0]   hold_dt;
   logic [7:0]   mtype;
   logic [31:0]  mlen;
   logic [31:0]  facc;
   logic [15:0]  trk_exp;
   logic [15:0]  trk_done;
   rsp_item_type expected_q[$];
   rsp_item_type made[$];
   int           mismatch_count;

   function automatic rsp_item_type mk(kind_type k, logic [15:0] trk, logic [31:0] tk,
                                       logic [7:0] st, logic [7:0] d1, logic [7:0] d2,
                                       logic [23:0] w, logic [15:0] tot);
      rsp_item_type r;
      r.kind = k;
      r.track_index = trk;
      r.tick = tk;
      r.status_byte = st;
      r.first_data = d1;
      r.second_data = d2;
      r.wide_value = w;
      r.track_total = tot;
      r.last = 1'b0;
      return r;
   endfunction

   task automatic add_made(rsp_item_type r);
      made.insert(made.size(), r);
   endtask

   task automatic clear_parser();
      ph = PH_MAGIC;
      bpos = '0;
      chunk_left = '0;
      skip_left = '0;
      vacc = '0;
      vcnt = '0;
      ticks = '0;
      run_st = '0;
      hold_st = '0;
      hold_dt = '0;
      mtype = '0;
      mlen = '0;
      facc = '0;
      trk_exp = '0;
      trk_done = '0;
   endtask

   function automatic logic take_varint(logic [7:0] b);
      vacc = (vacc << 7) | {25'd0, b[6:0]};
      vcnt = vcnt + 3'd1;
      return !b[7] || ({29'd0, vcnt} >= 32'(VarintMaxBytesDefault));
   endfunction

   task automatic to_event();
      ph = PH_DELTA;
      vacc = '0;
      vcnt = '0;
   endtask

   task automatic to_chunk_id();
      ph = PH_CID;
      bpos = '0;
      facc = '0;
   endtask

   task automatic skip_for(logic [31:0] n);
      if (n == 32'd0) begin
         to_event();
      end else begin
         skip_left = n;
         ph = PH_ESKIP;
      end
   endtask

   task automatic track_end();
      add_made(mk(KIND_EOT, trk_done, ticks, '0, '0, '0, '0, '0));
      trk_done = trk_done + 16'd1;
   endtask

   task automatic after_chunk();
      if (trk_done == trk_exp) ph = PH_DONE;
      else to_chunk_id();
   endtask

   task automatic first_data_in(logic [7:0] b);
      hold_dt = b;
      if (hold_st[7:4] == NibProg || hold_st[7:4] == NibPress) begin
         add_made(mk(KIND_CHANNEL, trk_done, ticks, hold_st, b, '0, '0, '0));
         to_event();
      end else begin
         ph = PH_DATA2;
      end
   endtask

   task automatic track_step(logic [7:0] b);
      if (chunk_left != 32'd0) chunk_left = chunk_left - 32'd1;
      case (ph)
         PH_DELTA: begin
            if (take_varint(b)) begin
               ticks = ticks + vacc;
               ph = PH_STATUS;
            end
         end
         PH_STATUS: begin
            if (!b[7]) begin
               if (run_st == 8'd0) begin
                  track_end();
                  ph = PH_TAIL;
               end else begin
                  hold_st = run_st;
                  first_data_in(b);
               end
            end else if (b == MetaByte) begin
               ph = PH_MTYPE;
            end else if (b == SysexStart || b == SysexCont) begin
               run_st = '0;
               vacc = '0;
               vcnt = '0;
               ph = PH_SXLEN;
            end else begin
               run_st = b;
               hold_st = b;
               ph = PH_DATA1;
            end
         end
         PH_DATA1: first_data_in(b);
         PH_DATA2: begin
            add_made(mk(KIND_CHANNEL, trk_done, ticks, hold_st, hold_dt, b, '0, '0));
            to_event();
         end
         PH_MTYPE: begin
            mtype = b;
            if (b == MetaEot) begin
               track_end();
               ph = PH_TAIL;
            end else begin
               vacc = '0;
               vcnt = '0;
               ph = PH_MLEN;
            end
         end
         PH_MLEN: begin
            if (take_varint(b)) begin
               mlen = vacc;
               bpos = '0;
               facc = '0;
               if (mtype == MetaTempo && mlen == 32'd3) ph = PH_TEMPO;
               else if (mtype == MetaTsig && mlen >= 32'd4) ph = PH_TSIG;
               else skip_for(mlen);
            end
         end
         PH_TEMPO: begin
            facc = ((facc << 8) | {24'd0, b}) & 32'hFFFFFF;
            bpos = bpos + 3'd1;
            if (bpos >= 3'd3) begin
               bpos = '0;
               if (facc != 32'd0)
                  add_made(mk(KIND_TEMPO, trk_done, ticks, '0, '0, '0, facc[23:0], '0));
               to_event();
            end
         end
         PH_TSIG: begin
            if (bpos == 3'd0) hold_dt = b;
            else if (bpos == 3'd1) facc = (b < 8'd8) ? ((32'd1 << b) & 32'hFF) : 32'd0;
            bpos = bpos + 3'd1;
            if (bpos >= 3'd4) begin
               bpos = '0;
               add_made(mk(KIND_TSIG, trk_done, ticks, '0, hold_dt, facc[7:0], '0, '0));
               skip_for(mlen - 32'd4);
            end
         end
         PH_SXLEN: if (take_varint(b)) skip_for(vacc);
         PH_ESKIP: begin
            if (skip_left != 32'd0) skip_left = skip_left - 32'd1;
            if (skip_left == 32'd0) to_event();
         end
         default: ;
      endcase
      if (chunk_left == 32'd0) begin
         if (ph != PH_TAIL) track_end();
         after_chunk();
      end
   endtask

   task automatic parse_byte(logic [7:0] b, logic first);
      made.delete();
      if (first) clear_parser();
      case (ph)
         PH_MAGIC: begin
            if (b != TagMthd[31 - 8 * bpos[1:0] -: 8]) begin
               add_made(mk(KIND_ERROR, '0, '0, '0, '0, '0, '0, '0));
               ph = PH_ERROR;
            end else begin
               bpos = bpos + 3'd1;
               if (bpos >= 3'd4) begin
                  bpos = '0;
                  chunk_left = '0;
                  ph = PH_HLEN;
               end
            end
         end
         PH_HLEN: begin
            chunk_left = (chunk_left << 8) | {24'd0, b};
            bpos = bpos + 3'd1;
            if (bpos >= 3'd4) begin
               bpos = '0;
               if (chunk_left < 32'd6) begin
                  add_made(mk(KIND_ERROR, '0, '0, '0, '0, '0, '0, '0));
                  ph = PH_ERROR;
               end else begin
                  ph = PH_FMT;
               end
            end
         end
         PH_FMT: begin
            bpos = bpos + 3'd1;
            if (bpos >= 3'd2) begin
               bpos = '0;
               trk_exp = '0;
               ph = PH_NTRK;
            end
         end
         PH_NTRK: begin
            trk_exp = {trk_exp[7:0], b};
            bpos = bpos + 3'd1;
            if (bpos >= 3'd2) begin
               bpos = '0;
               facc = '0;
               ph = PH_TPQN;
            end
         end
         PH_TPQN: begin
            facc = ((facc << 8) | {24'd0, b}) & 32'hFFFF;
            bpos = bpos + 3'd1;
            if (bpos >= 3'd2) begin
               bpos = '0;
               add_made(mk(KIND_HEADER, '0, '0, '0, '0, '0, facc[23:0], trk_exp));
               skip_left = chunk_left - 32'd6;
               if (trk_exp == 16'd0) ph = PH_DONE;
               else if (skip_left != 32'd0) ph = PH_CSKIP;
               else to_chunk_id();
            end
         end
         PH_CID: begin
            facc = (facc << 8) | {24'd0, b};
            bpos = bpos + 3'd1;
            if (bpos >= 3'd4) begin
               bpos = '0;
               chunk_left = '0;
               ph = PH_CLEN;
            end
         end
         PH_CLEN: begin
            chunk_left = (chunk_left << 8) | {24'd0, b};
            bpos = bpos + 3'd1;
            if (bpos >= 3'd4) begin
               bpos = '0;
               if (facc == TagMtrk) begin
                  ticks = '0;
                  run_st = '0;
                  if (chunk_left == 32'd0) begin
                     track_end();
                     after_chunk();
                  end else begin
                     to_event();
                  end
               end else if (chunk_left == 32'd0) begin
                  to_chunk_id();
               end else begin
                  skip_left = chunk_left;
                  ph = PH_CSKIP;
               end
            end
         end
         PH_CSKIP: begin
            if (skip_left != 32'd0) skip_left = skip_left - 32'd1;
            if (skip_left == 32'd0) to_chunk_id();
         end
         PH_DONE, PH_ERROR: ;
         default: track_step(b);
      endcase
      if (made.size() > 0) made[made.size() - 1].last = 1'b1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parser();
         expected_q.delete();
         mismatch_count <= 0;
         result_count <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            result_count <= result_count + 1;
            if (expected_q.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected result item %p", rsp_mon.item);
               mismatch_count <= mismatch_count + 1;
            end else begin
               if (rsp_mon.item !== expected_q[0]) begin
                  if (mismatch_count < 10)
                     $display("mismatch: expected %p, actual %p", expected_q[0], rsp_mon.item);
                  mismatch_count <= mismatch_count + 1;
               end
               void'(expected_q.pop_front());
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            parse_byte(req_mon.file_byte, req_mon.new_file);
            foreach (made[i]) expected_q.insert(expected_q.size(), made[i]);
         end
      end
   end

   assign error_count = mismatch_count;
   assign pending_count = expected_q.size();

endmodule

// ===== tb/midi_file_event_parser_top_test.sv =====
// testbench top: builds midi file byte streams, drives the parser and gives the verdict
module midi_file_event_parser_top_test;
   import mfep_pkg::*;

   logic clock;
   logic reset;
   int   error_count;
   int   pending_count;
   int   result_count;
   int   byte_count;
   int   file_count;
   int   cycle_count;
   logic [7:0] file_q[$];

   mfep_req_if req_if ();
   mfep_rsp_if rsp_if ();

   midi_file_event_parser_top DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source)
   );

   mfep_scoreboard checker_unit (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_if.sink),
      .rsp_mon       (rsp_if.sink),
      .error_count   (error_count),
      .pending_count (pending_count),
      .result_count  (result_count)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   // result side stalls
   initial begin
      rsp_if.ready = 0;
      @(negedge clock);
      forever begin
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         if ($urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap_len() + 1) @(negedge clock);
         end
      end
   end

   task automatic put8(logic [7:0] v);
      file_q.insert(file_q.size(), v);
   endtask

   task automatic put32(logic [31:0] v);
      for (int i = 3; i >= 0; i--) put8(v[8 * i +: 8]);
   endtask

   task automatic put_varint(logic [31:0] v, int nbytes);
      for (int i = nbytes - 1; i >= 0; i--)
         put8({i != 0, v[7 * i +: 7]});
   endtask

   // one track body: random events, mostly well formed
   task automatic put_track_body(int events, logic ok_end);
      int p;
      int n;
      for (int e = 0; e < events; e++) begin
         n = $urandom_range(1, 4);
         put_varint((n == 4) ? $urandom() : $urandom_range(0, 127), n);
         p = $urandom_range(0, 99);
         if (p < 40) begin
            put8({1'b1, 3'($urandom_range(0, 6)), 4'($urandom())});
            put8(8'($urandom()));
            put8(8'($urandom()));
         end else if (p < 55) begin
            put8(8'($urandom_range(0, 127)));
            put8(8'($urandom()));
         end else if (p < 65) begin
            put8(8'hFF);
            put8(MetaTempo);
            put8(8'd3);
            if ($urandom_range(0, 5) == 0) begin
               put8(8'd0);
               put8(8'd0);
               put8(8'd0);
            end else begin
               put8(8'($urandom()));
               put8(8'($urandom()));
               put8(8'($urandom()));
            end
         end else if (p < 75) begin
            n = $urandom_range(4, 6);
            put8(8'hFF);
            put8(MetaTsig);
            put8(8'(n));
            for (int i = 0; i < n; i++) put8(8'($urandom_range(0, 10)));
         end else if (p < 85) begin
            n = $urandom_range(0, 4);
            put8(8'hFF);
            put8(8'($urandom_range(0, 127)));
            put8(8'(n));
            for (int i = 0; i < n; i++) put8(8'($urandom()));
         end else if (p < 93) begin
            n = $urandom_range(0, 4);
            put8($urandom_range(0, 1) ? SysexStart : SysexCont);
            put8(8'(n));
            for (int i = 0; i < n; i++) put8(8'($urandom()));
         end else begin
            put8(8'($urandom()));
         end
      end
      if (ok_end) begin
         put8(8'd0);
         put8(8'hFF);
         put8(MetaEot);
         put8(8'd0);
      end
   endtask

   // whole file with header, random chunks and tracks
   task automatic build_file();
      int ntrk;
      int start;
      int len;
      int extra;
      file_q.delete();
      ntrk = $urandom_range(1, 3);
      extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
      put32(TagMthd);
      put32(6 + extra);
      put8(8'd0);
      put8(8'($urandom_range(0, 2)));
      put8(8'd0);
      put8(8'(ntrk));
      put8(8'($urandom()));
      put8(8'($urandom()));
      for (int i = 0; i < extra; i++) put8(8'($urandom()));
      for (int t = 0; t < ntrk; t++) begin
         if ($urandom_range(0, 4) == 0) begin
            put32(32'h58595A21);
            len = $urandom_range(0, 3);
            put32(len);
            for (int i = 0; i < len; i++) put8(8'($urandom()));
         end
         put32(TagMtrk);
         start = file_q.size();
         put32(0);
         put_track_body($urandom_range(0, 6), $urandom_range(0, 3) != 0);
         len = file_q.size() - start - 4;
         // sometimes cut the track short or make it long
         if ($urandom_range(0, 5) == 0 && len > 1) len = $urandom_range(1, len);
         else if ($urandom_range(0, 5) == 0) begin
            for (int i = 0; i < 3; i++) put8(8'($urandom()));
            len = len + 3;
         end
         for (int i = 0; i < 4; i++) file_q[start + i] = len[31 - 8 * i -: 8];
      end
      if ($urandom_range(0, 5) == 0) put32($urandom());
   endtask

   task automatic send_file();
      int gap;
      foreach (file_q[i]) begin
         req_if.valid <= 1'b1;
         req_if.file_byte <= file_q[i];
         req_if.new_file <= (i == 0);
         @(posedge clock);
         while (!req_if.ready) @(posedge clock);
         byte_count++;
         @(negedge clock);
         gap = ($urandom_range(0, 1) == 0) ? gap_len() : 0;
         if (i == file_q.size() - 1 && gap == 0) gap = 1;
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      file_count++;
   endtask

   initial begin
      byte_count = 0;
      file_count = 0;
      req_if.valid = 0;
      req_if.file_byte = 0;
      req_if.new_file = 0;
      reset = 1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // bad magic, short header, zero tracks
      file_q = '{8'h4D, 8'h54, 8'h00, 8'h68};
      send_file();
      file_q = '{8'h4D, 8'h54, 8'h68, 8'h64, 8'h00, 8'h00, 8'h00, 8'h05, 8'h11};
      send_file();
      file_q = '{8'h4D, 8'h54, 8'h68, 8'h64, 8'h00, 8'h00, 8'h00, 8'h06,
                 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h4D};
      send_file();
      // header extremes, empty track, missing running status, f1 status, long varint
      file_q.delete();
      put32(TagMthd);
      put32(32'h0000_0007);
      file_q = {file_q, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hAA};
      put32(TagMtrk);
      put32(0);
      put32(TagMtrk);
      put32(3);
      file_q = {file_q, 8'h00, 8'h40, 8'h00};
      put32(TagMtrk);
      put32(32'd22);
      file_q = {file_q, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hF1, 8'h00, 8'hFF,
                8'h00, 8'hC5, 8'h80, 8'h00, 8'hD2, 8'h7F,
                8'h00, 8'hFF, 8'h51, 8'h03, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h90};
      send_file();

      while (byte_count < 700) begin
         build_file();
         send_file();
      end

      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("sent %0d files, %0d bytes; checked %0d result items",
               file_count, byte_count, result_count);
      if (error_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
